/* hdl/rfls_pkg.sv */
// Shared types and constants for the redundant frame link supervisor.
`timescale 1ns / 1ps

package rfls_pkg;

    localparam int STORE_DEPTH_DEF = 32;
    localparam int COPIES_DEF      = 3;

    // Each payload copy holds source, target and pump command
    localparam int FIELDS_PER_COPY = 3;

    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [7:0] SYNC_HI = 8'hAA;
    localparam logic [7:0] SYNC_LO = 8'h5A;
    localparam logic [7:0] END_HI  = 8'hCC;
    localparam logic [7:0] END_LO  = 8'hC3;
    localparam logic [7:0] PAD     = 8'h00;

    localparam logic [7:0] SECOND_LIMIT_RST  = 8'd200;
    localparam logic [7:0] OFFLINE_LIMIT_RST = 8'd29;
    localparam logic [7:0] IDLE_LIMIT_RST    = 8'd100;
    localparam logic [7:0] SOURCE_RST        = 8'hAB;
    localparam logic [7:0] TARGET_RST        = 8'hEF;

    // Lowest pointer value at which an end pair may be recognized, minus one
    localparam int END_MIN_PTR = 4;

    // Positions within one payload copy
    localparam logic [1:0] FLD_SRC = 2'd0;
    localparam logic [1:0] FLD_TGT = 2'd1;
    localparam logic [1:0] FLD_CMD = 2'd2;

    typedef enum logic [2:0] {
        REG_SECOND_LIMIT  = 3'd0,
        REG_OFFLINE_LIMIT = 3'd1,
        REG_IDLE_LIMIT    = 3'd2,
        REG_SOURCE        = 3'd3,
        REG_TARGET        = 3'd4
    } reg_idx_t;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic [7:0] second_limit;
        logic [7:0] offline_limit;
        logic [7:0] idle_limit;
        logic [7:0] source;
        logic [7:0] target;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_PREV,
        ST_CHECK,
        ST_PAY,
        ST_DECIDE,
        ST_REPLY,
        ST_EMIT
    } state_t;

endpackage

/* hdl/rfls_regs.sv */
// APB register file holding the supervisor configuration.
`timescale 1ns / 1ps

module rfls_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfls_pkg::APB_AW-1:0] paddr,
    input  logic [rfls_pkg::APB_DW-1:0] pwdata,
    output logic [rfls_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output rfls_pkg::cfg_t             cfg
);

    rfls_pkg::cfg_t   cfg_reg;
    rfls_pkg::cfg_t   cfg_next;
    rfls_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = rfls_pkg::reg_idx_t'(paddr[rfls_pkg::APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                rfls_pkg::REG_SECOND_LIMIT:  cfg_next.second_limit  = pwdata[7:0];
                rfls_pkg::REG_OFFLINE_LIMIT: cfg_next.offline_limit = pwdata[7:0];
                rfls_pkg::REG_IDLE_LIMIT:    cfg_next.idle_limit    = pwdata[7:0];
                rfls_pkg::REG_SOURCE:        cfg_next.source        = pwdata[7:0];
                rfls_pkg::REG_TARGET:        cfg_next.target        = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rfls_pkg::REG_SECOND_LIMIT:  prdata = {24'd0, cfg_reg.second_limit};
            rfls_pkg::REG_OFFLINE_LIMIT: prdata = {24'd0, cfg_reg.offline_limit};
            rfls_pkg::REG_IDLE_LIMIT:    prdata = {24'd0, cfg_reg.idle_limit};
            rfls_pkg::REG_SOURCE:        prdata = {24'd0, cfg_reg.source};
            rfls_pkg::REG_TARGET:        prdata = {24'd0, cfg_reg.target};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.second_limit  <= rfls_pkg::SECOND_LIMIT_RST;
            cfg_reg.offline_limit <= rfls_pkg::OFFLINE_LIMIT_RST;
            cfg_reg.idle_limit    <= rfls_pkg::IDLE_LIMIT_RST;
            cfg_reg.source        <= rfls_pkg::SOURCE_RST;
            cfg_reg.target        <= rfls_pkg::TARGET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/rfls_store.sv */
// Receive ring memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module rfls_store
#(
    parameter int STORE_DEPTH = rfls_pkg::STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0]             mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_vld_reg;

    // Never-written entries read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : 8'd0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

endmodule

/* hdl/rfls_ctrl.sv */
// Sequencer: frame detection, payload vote, timers and reply generation.
`timescale 1ns / 1ps

module rfls_ctrl
#(
    parameter int STORE_DEPTH = rfls_pkg::STORE_DEPTH_DEF,
    parameter int COPIES      = rfls_pkg::COPIES_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  rfls_pkg::cfg_t                   cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rfls_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rfls_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast,
    output logic                             mem_wr_en,
    output logic [AW-1:0]                    mem_wr_addr,
    output logic [7:0]                       mem_wr_data,
    output logic [AW-1:0]                    mem_rd_addr,
    input  logic [7:0]                       mem_rd_data
);

    localparam int PAY_N = rfls_pkg::FIELDS_PER_COPY * COPIES;
    localparam int CW    = $clog2(PAY_N + 1);
    localparam int REP_N = PAY_N + 4;
    localparam int EW    = $clog2(REP_N);

    localparam logic [AW-1:0] WP_LAST = AW'(STORE_DEPTH - 2);
    localparam logic [AW-1:0] WP_MIN  = AW'(rfls_pkg::END_MIN_PTR);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(STORE_DEPTH);
    localparam logic [CW-1:0] PAY_END = CW'(PAY_N);
    localparam logic [CW-1:0] FIRST_COPY_END = CW'(rfls_pkg::FIELDS_PER_COPY);
    localparam logic [EW-1:0] REP_LAST = EW'(REP_N - 1);
    localparam logic [EW-1:0] REP_PRE  = EW'(REP_N - 2);

    rfls_pkg::state_t state_reg, state_next;

    logic [AW-1:0] wp_reg, wp_next;
    logic          in_frame_reg, in_frame_next;
    logic [7:0]    prev_reg, prev_next;
    logic [AW-1:0] start_reg, start_next;
    logic [7:0]    idle_reg, idle_next;
    logic [7:0]    sec_tick_reg, sec_tick_next;
    logic [7:0]    osec_reg, osec_next;
    logic          online_reg, online_next;
    logic [7:0]    pump_reg, pump_next;
    logic          wrote_reg, wrote_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    lane_reg, lane_next;
    logic          bad_reg, bad_next;
    logic [EW-1:0] emit_reg, emit_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    cur_reg, cur_next;
    logic [7:0]    ref_reg [rfls_pkg::FIELDS_PER_COPY];
    logic          ref_we;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_txv_reg, out_txv_next;
    logic          out_last_reg, out_last_next;
    logic          out_pump_reg, out_pump_next;
    logic          out_online_reg, out_online_next;

    logic          accept;
    logic          slot_free;
    logic [AW:0]   pay_sum;
    logic [AW-1:0] pay_addr;
    logic [1:0]    lane_inc;
    logic [7:0]    sec_inc;
    logic [7:0]    osec_inc;
    logic          frame_ok;

    assign s_tready  = (state_reg == rfls_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    assign pay_sum  = {1'b0, start_reg} + (AW + 1)'(cnt_reg);
    assign pay_addr = (pay_sum >= DEPTH_W) ? AW'(pay_sum - DEPTH_W) : pay_sum[AW-1:0];
    assign lane_inc = (lane_reg == FIELDS_PER_COPY_LAST()) ? 2'd0 : lane_reg + 2'd1;
    assign sec_inc  = sec_tick_reg + 8'd1;
    assign osec_inc = osec_reg + 8'd1;
    assign frame_ok = !bad_reg
                      && (ref_reg[rfls_pkg::FLD_SRC] == cfg.source)
                      && (ref_reg[rfls_pkg::FLD_TGT] == cfg.target);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_byte_reg, out_online_reg, out_pump_reg};
    assign m_tuser  = out_txv_reg;
    assign m_tlast  = out_last_reg;

    function automatic logic [1:0] FIELDS_PER_COPY_LAST();
        return 2'(rfls_pkg::FIELDS_PER_COPY - 1);
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        in_frame_next   = in_frame_reg;
        prev_next       = prev_reg;
        start_next      = start_reg;
        idle_next       = idle_reg;
        sec_tick_next   = sec_tick_reg;
        osec_next       = osec_reg;
        online_next     = online_reg;
        pump_next       = pump_reg;
        wrote_next      = wrote_reg;
        cnt_next        = cnt_reg;
        lane_next       = lane_reg;
        bad_next        = bad_reg;
        emit_next       = emit_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        byte_next       = byte_reg;
        cur_next        = cur_reg;
        ref_we          = 1'b0;
        out_byte_next   = out_byte_reg;
        out_txv_next    = out_txv_reg;
        out_last_next   = out_last_reg;
        out_pump_next   = out_pump_reg;
        out_online_next = out_online_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = wp_reg;
        mem_wr_data     = s_tdata;
        mem_rd_addr     = wp_reg;

        case (state_reg)
            rfls_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (rfls_pkg::op_t'(s_tuser[0]) == rfls_pkg::OP_TICK)
                    begin
                        sec_tick_next = sec_inc;
                        if (idle_reg != 8'hFF)
                        begin
                            idle_next = idle_reg + 8'd1;
                        end
                        if (idle_next >= cfg.idle_limit)
                        begin
                            wp_next = '0;
                        end
                        if (sec_inc > cfg.second_limit)
                        begin
                            sec_tick_next = 8'd0;
                            osec_next     = osec_inc;
                            if (osec_inc > cfg.offline_limit)
                            begin
                                osec_next   = 8'd0;
                                online_next = 1'b0;
                            end
                        end
                        state_next = rfls_pkg::ST_EMIT;
                    end
                    else
                    begin
                        // frame start opens the store for writing at this slot
                        if (s_tdata == rfls_pkg::SYNC_LO && prev_reg == rfls_pkg::SYNC_HI)
                        begin
                            in_frame_next = 1'b1;
                            start_next    = wp_reg + AW'(1);
                        end
                        mem_wr_en   = in_frame_next;
                        wrote_next  = in_frame_next;
                        byte_next   = s_tdata;
                        prev_next   = s_tdata;
                        idle_next   = 8'd0;
                        mem_rd_addr = wp_reg;
                        state_next  = rfls_pkg::ST_RD_PREV;
                    end
                end
            end

            rfls_pkg::ST_RD_PREV:
            begin
                cur_next    = wrote_reg ? byte_reg : mem_rd_data;
                mem_rd_addr = wp_reg - AW'(1);
                state_next  = rfls_pkg::ST_CHECK;
            end

            rfls_pkg::ST_CHECK:
            begin
                if (wp_reg > WP_MIN && cur_reg == rfls_pkg::END_LO
                    && mem_rd_data == rfls_pkg::END_HI)
                begin
                    in_frame_next = 1'b0;
                    wp_next       = '0;
                    cnt_next      = '0;
                    lane_next     = 2'd0;
                    bad_next      = 1'b0;
                    state_next    = rfls_pkg::ST_PAY;
                end
                else
                begin
                    wp_next    = (wp_reg == WP_LAST) ? '0 : wp_reg + AW'(1);
                    state_next = rfls_pkg::ST_EMIT;
                end
            end

            rfls_pkg::ST_PAY:
            begin
                // one read issued and one byte checked per cycle
                mem_rd_addr = pay_addr;
                if (cnt_reg != '0)
                begin
                    lane_next = lane_inc;
                    if (cnt_reg <= FIRST_COPY_END)
                    begin
                        ref_we = 1'b1;
                    end
                    else if (mem_rd_data != ref_reg[lane_reg])
                    begin
                        bad_next = 1'b1;
                    end
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == PAY_END)
                begin
                    state_next = rfls_pkg::ST_DECIDE;
                end
            end

            rfls_pkg::ST_DECIDE:
            begin
                if (frame_ok)
                begin
                    online_next = 1'b1;
                    osec_next   = 8'd0;
                    pump_next   = ref_reg[rfls_pkg::FLD_CMD];
                    emit_next   = '0;
                    lane_next   = 2'd0;
                    state_next  = rfls_pkg::ST_REPLY;
                end
                else
                begin
                    state_next = rfls_pkg::ST_EMIT;
                end
            end

            rfls_pkg::ST_REPLY:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_txv_next    = 1'b1;
                    out_pump_next   = online_reg && (pump_reg != 8'd0);
                    out_online_next = online_reg;
                    out_last_next   = (emit_reg == REP_LAST);
                    if (emit_reg == '0)
                    begin
                        out_byte_next = rfls_pkg::SYNC_HI;
                    end
                    else if (emit_reg == EW'(1))
                    begin
                        out_byte_next = rfls_pkg::SYNC_LO;
                    end
                    else if (emit_reg == REP_PRE)
                    begin
                        out_byte_next = rfls_pkg::END_HI;
                    end
                    else if (emit_reg == REP_LAST)
                    begin
                        out_byte_next = rfls_pkg::END_LO;
                    end
                    else
                    begin
                        lane_next = lane_inc;
                        case (lane_reg)
                            rfls_pkg::FLD_SRC: out_byte_next = cfg.target;
                            rfls_pkg::FLD_TGT: out_byte_next = pump_reg;
                            default:           out_byte_next = rfls_pkg::PAD;
                        endcase
                    end
                    emit_next = emit_reg + EW'(1);
                    if (emit_reg == REP_LAST)
                    begin
                        state_next = rfls_pkg::ST_IDLE;
                    end
                end
            end

            rfls_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_txv_next    = 1'b0;
                    out_byte_next   = 8'd0;
                    out_last_next   = 1'b1;
                    out_pump_next   = online_reg && (pump_reg != 8'd0);
                    out_online_next = online_reg;
                    state_next      = rfls_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rfls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfls_pkg::ST_IDLE;
            wp_reg        <= '0;
            in_frame_reg  <= 1'b0;
            prev_reg      <= 8'd0;
            start_reg     <= '0;
            idle_reg      <= 8'd0;
            sec_tick_reg  <= 8'd0;
            osec_reg      <= 8'd0;
            online_reg    <= 1'b0;
            pump_reg      <= 8'd0;
            wrote_reg     <= 1'b0;
            cnt_reg       <= '0;
            lane_reg      <= 2'd0;
            bad_reg       <= 1'b0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            in_frame_reg  <= in_frame_next;
            prev_reg      <= prev_next;
            start_reg     <= start_next;
            idle_reg      <= idle_next;
            sec_tick_reg  <= sec_tick_next;
            osec_reg      <= osec_next;
            online_reg    <= online_next;
            pump_reg      <= pump_next;
            wrote_reg     <= wrote_next;
            cnt_reg       <= cnt_next;
            lane_reg      <= lane_next;
            bad_reg       <= bad_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        cur_reg        <= cur_next;
        out_byte_reg   <= out_byte_next;
        out_txv_reg    <= out_txv_next;
        out_last_reg   <= out_last_next;
        out_pump_reg   <= out_pump_next;
        out_online_reg <= out_online_next;
        if (ref_we)
        begin
            ref_reg[lane_reg] <= mem_rd_data;
        end
    end

endmodule

/* hdl/redundant_frame_link_supervisor.sv */
// Top level of the redundant frame link supervisor.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): one word per received serial byte or 5 ms tick.
//     s_tuser selects the kind (0 byte, 1 tick), s_tdata carries the byte.
//   Output stream (m_*): one word per input, or a 13-word reply frame
//     (AA 5A, three copies of target/pump/00, CC C3) when a frame with
//     three matching payload copies and correct addresses closes.
//     m_tlast marks the final word caused by an input.
//   APB: five 8-bit regs at 0x00..0x10, written while idle (user's duty, unchecked).
// Timing
//   One item is worked on at a time. A tick goes to EMIT for its word, a byte
//   through RD_PREV (ring read of the current and previous slot), CHECK and EMIT.
//   A frame end adds the payload vote (PAY, DECIDE), one read per byte on the
//   single ring read port, then one reply word per cycle while m_tready is high.
//   s_tready returns in the same cycle as the last word enters the output
//   register, so a new item is taken while that word still waits.
// Reset
//   rst_n clears all counters, the sequencer flags and the ring valid bits at once;
//   entries never written read as zero. No clearing pass is needed.
// Backpressure
//   A stalled m_tready holds the output word and pauses the sequencer at its next output word.

module redundant_frame_link_supervisor
#(
    parameter int STORE_DEPTH = rfls_pkg::STORE_DEPTH_DEF,
    parameter int COPIES      = rfls_pkg::COPIES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfls_pkg::APB_AW-1:0]     paddr,
    input  logic [rfls_pkg::APB_DW-1:0]     pwdata,
    output logic [rfls_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rfls_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] rx_byte
    input  logic [0:0]                      s_tuser,  // [0] operation
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rfls_pkg::OUT_DATA_W-1:0] m_tdata,  // [0] pump_on, [1] link_online,
                                                      // [9:2] tx_byte, [15:10] zero
    output logic [0:0]                      m_tuser,  // [0] tx_valid
    output logic                            m_tlast   // last
);

    localparam int AW = $clog2(STORE_DEPTH);

    rfls_pkg::cfg_t cfg;
    logic           mem_wr_en;
    logic [AW-1:0]  mem_wr_addr;
    logic [7:0]     mem_wr_data;
    logic [AW-1:0]  mem_rd_addr;
    logic [7:0]     mem_rd_data;

    rfls_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ring of received bytes
    rfls_store
    #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    )
    u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rfls_ctrl
    #(
        .STORE_DEPTH (STORE_DEPTH),
        .COPIES      (COPIES),
        .AW          (AW)
    )
    u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

endmodule

/* hdl/rfls_checker.sv */
// Port-level checks for the supervisor, bound to the top level.
`timescale 1ns / 1ps

module rfls_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rfls_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [0:0]                      m_tuser,
    input  logic                            m_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    // a plain status word carries no byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[9:2] == 8'd0)
        else $error("status word with nonzero byte");

    // a status word is always the only word of its input
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("status word without last");

    // pump may run only while the link is online
    a_pump_online: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[0] || m_tdata[1])
        else $error("pump on while link offline");

endmodule

bind redundant_frame_link_supervisor rfls_checker u_rfls_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/redundant_frame_link_supervisor_tb.sv */
// Self-checking testbench for the redundant frame link supervisor.
`timescale 1ns / 1ps

module redundant_frame_link_supervisor_tb;

    import rfls_pkg::*;

    localparam int STORE_DEPTH   = STORE_DEPTH_DEF;
    localparam int COPIES        = COPIES_DEF;
    localparam int PAYLOAD_BYTES = COPIES * FIELDS_PER_COPY;
    localparam int SETTLE_CYCLES = 40;       // covers a full frame end plus reply
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 100;

    typedef logic [$clog2(STORE_DEPTH)-1:0] ring_ptr_t;

    // one output word as the checker sees it
    typedef struct packed {
        logic       pump_on;
        logic       link_online;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
    } reply_word_t;

    // directed row; typed rows carry their single expected word inline
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       typed;
        logic       pump_on;
        logic       link_online;
    } directed_row_t;

    typedef enum int {
        FR_GOOD,
        FR_COPY_BAD,
        FR_ADDR_BAD,
        FR_CUT
    } frame_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [7:0] rx_byte
    logic [0:0]            s_tuser;   // [0] operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [0] pump_on, [1] link_online, [9:2] tx_byte
    logic [0:0]            m_tuser;   // [0] tx_valid
    logic                  m_tlast;

    // predicted link state
    cfg_t        regs_now;
    logic [7:0]  ring [STORE_DEPTH];
    ring_ptr_t   ring_ptr;
    ring_ptr_t   pay_start;
    logic        in_frame;
    logic [7:0]  last_rx;
    logic [7:0]  idle_ticks;
    logic [7:0]  sec_ticks;
    logic [7:0]  online_secs;
    logic        online;
    logic [7:0]  pump_cmd;

    reply_word_t words_due [$];
    int          mismatches  = 0;
    int          words_seen  = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int unsigned cycle_count = 0;
    logic [9:0]  stall_phase;

    directed_row_t directed_rows [19] = '{
        '{OP_TICK, 8'h00,         1'b1, 1'b0, 1'b0},   // tick right after reset
        '{OP_BYTE, 8'h00,         1'b1, 1'b0, 1'b0},
        '{OP_BYTE, 8'hFF,         1'b1, 1'b0, 1'b0},
        '{OP_TICK, 8'hFF,         1'b1, 1'b0, 1'b0},
        '{OP_BYTE, SYNC_HI,       1'b1, 1'b0, 1'b0},   // sync pair, frame opens on the second byte
        '{OP_BYTE, SYNC_LO,       1'b1, 1'b0, 1'b0},
        '{OP_BYTE, SOURCE_RST,    1'b1, 1'b0, 1'b0},
        '{OP_BYTE, TARGET_RST,    1'b1, 1'b0, 1'b0},
        '{OP_BYTE, 8'hFF,         1'b1, 1'b0, 1'b0},
        '{OP_BYTE, SOURCE_RST,    1'b1, 1'b0, 1'b0},
        '{OP_BYTE, TARGET_RST,    1'b1, 1'b0, 1'b0},
        '{OP_BYTE, 8'hFF,         1'b1, 1'b0, 1'b0},
        '{OP_BYTE, SOURCE_RST,    1'b1, 1'b0, 1'b0},
        '{OP_BYTE, TARGET_RST,    1'b1, 1'b0, 1'b0},
        '{OP_BYTE, 8'hFF,         1'b1, 1'b0, 1'b0},
        '{OP_BYTE, END_HI,        1'b1, 1'b0, 1'b0},
        '{OP_BYTE, END_LO,        1'b0, 1'b0, 1'b0},   // closes: full reply
        '{OP_TICK, 8'h00,         1'b1, 1'b1, 1'b1},   // online, pump command FF
        '{OP_BYTE, END_LO,        1'b1, 1'b1, 1'b1}    // stray end byte at slot 0
    };

    redundant_frame_link_supervisor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("redundant_frame_link_supervisor_tb: errors");
            $finish;
        end
    end

    // receiver: ready always, mostly, at random, or in long stalls
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 10'd1;
        case (stall_phase[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= (stall_phase[1:0] != 2'd0);
            2'd2: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (stall_phase[2:0] == 3'd0);
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("word %0d: %s got %0h want %0h", words_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        reply_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_seen++;
            if (words_due.size() == 0)
                report_mismatch("unexpected word, tdata", m_tdata, 0);
            else
            begin
                want = words_due.pop_front();
                if (m_tdata[0] !== want.pump_on)
                    report_mismatch("pump_on", m_tdata[0], want.pump_on);
                if (m_tdata[1] !== want.link_online)
                    report_mismatch("link_online", m_tdata[1], want.link_online);
                if (m_tuser[0] !== want.tx_valid)
                    report_mismatch("tx_valid", m_tuser[0], want.tx_valid);
                if (m_tdata[9:2] !== want.tx_byte)
                    report_mismatch("tx_byte", m_tdata[9:2], want.tx_byte);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    function automatic reply_word_t make_word(input logic valid, input logic [7:0] data,
                                              input logic fin);
        reply_word_t w;
        w.pump_on     = online && (pump_cmd != 8'h00);
        w.link_online = online;
        w.tx_valid    = valid;
        w.tx_byte     = valid ? data : 8'h00;
        w.last        = fin;
        return w;
    endfunction

    // Advance the predicted link state by one input; queue its words if asked.
    task automatic advance_link(input op_t op, input logic [7:0] b, input bit record);
        ring_ptr_t wp;
        bit        ended;
        bit        ok;
        if (op == OP_BYTE)
        begin
            wp = ring_ptr;
            if (b == SYNC_LO && last_rx == SYNC_HI)
            begin
                in_frame  = 1'b1;
                pay_start = wp + 1'b1;
            end
            // bytes outside a frame are dropped, the pointer still moves
            if (in_frame)
                ring[wp] = b;
            ended = (wp > END_MIN_PTR) && (ring[wp] == END_LO) && (ring[wp - 1'b1] == END_HI);
            if (ended)
                in_frame = 1'b0;
            ring_ptr   = (wp >= STORE_DEPTH - 2) ? '0 : wp + 1'b1;
            last_rx    = b;
            idle_ticks = 8'h00;
            if (ended)
            begin
                ring_ptr = '0;
                ok = 1'b1;
                // every copy must match the first one, slots wrap around the ring
                for (int c = 1; c < COPIES; c++)
                    for (int k = 0; k < FIELDS_PER_COPY; k++)
                        if (ring[(pay_start + k) % STORE_DEPTH] !=
                            ring[(pay_start + FIELDS_PER_COPY * c + k) % STORE_DEPTH])
                            ok = 1'b0;
                if (ring[(pay_start + FLD_SRC) % STORE_DEPTH] != regs_now.source ||
                    ring[(pay_start + FLD_TGT) % STORE_DEPTH] != regs_now.target)
                    ok = 1'b0;
                if (ok)
                begin
                    online      = 1'b1;
                    online_secs = 8'h00;
                    pump_cmd    = ring[(pay_start + FLD_CMD) % STORE_DEPTH];
                    if (record)
                    begin
                        words_due.push_back(make_word(1'b1, SYNC_HI, 1'b0));
                        words_due.push_back(make_word(1'b1, SYNC_LO, 1'b0));
                        for (int c = 0; c < COPIES; c++)
                        begin
                            words_due.push_back(make_word(1'b1, regs_now.target, 1'b0));
                            words_due.push_back(make_word(1'b1, pump_cmd, 1'b0));
                            words_due.push_back(make_word(1'b1, PAD, 1'b0));
                        end
                        words_due.push_back(make_word(1'b1, END_HI, 1'b0));
                        words_due.push_back(make_word(1'b1, END_LO, 1'b1));
                    end
                    return;
                end
            end
        end
        else
        begin
            sec_ticks = sec_ticks + 8'd1;
            if (idle_ticks != 8'hFF)
                idle_ticks = idle_ticks + 8'd1;
            // pointer clears once idle ticks reach the idle limit; in_frame is left alone
            if (idle_ticks >= regs_now.idle_limit)
                ring_ptr = '0;
            if (sec_ticks > regs_now.second_limit)
            begin
                sec_ticks   = 8'h00;
                online_secs = online_secs + 8'd1;
                if (online_secs > regs_now.offline_limit)
                begin
                    online_secs = 8'h00;
                    online      = 1'b0;
                end
            end
        end
        if (record)
            words_due.push_back(make_word(1'b0, PAD, 1'b1));
    endtask

    // Present one word and hold it until taken; then maybe open a gap.
    task automatic send_item(input op_t op, input logic [7:0] data, input bit typed,
                             input logic want_pump, input logic want_online);
        reply_word_t w;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        advance_link(op, data, !typed);
        if (typed)
        begin
            w.pump_on     = want_pump;
            w.link_online = want_online;
            w.tx_valid    = 1'b0;
            w.tx_byte     = 8'h00;
            w.last        = 1'b1;
            words_due.push_back(w);
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 8);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, b, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_item(OP_TICK, 8'($urandom), 1'b0, 1'b0, 1'b0);
    endtask

    // noise leans on the framing bytes so stray sync and end pairs show up
    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            case ($urandom_range(0, 7))
                0: b = SYNC_HI;
                1: b = SYNC_LO;
                2: b = END_HI;
                3: b = END_LO;
                default: b = 8'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] pay [PAYLOAD_BYTES];
        logic [7:0] cmd;
        logic [7:0] flip;
        int         pick;
        int         n;
        cmd  = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
        flip = 8'($urandom_range(1, 255));
        for (int c = 0; c < COPIES; c++)
        begin
            pay[FIELDS_PER_COPY * c + FLD_SRC] = regs_now.source;
            pay[FIELDS_PER_COPY * c + FLD_TGT] = regs_now.target;
            pay[FIELDS_PER_COPY * c + FLD_CMD] = cmd;
        end
        case (kind)
            FR_COPY_BAD:
            begin
                pick = $urandom_range(FIELDS_PER_COPY, PAYLOAD_BYTES - 1);
                pay[pick] = pay[pick] ^ flip;
            end
            FR_ADDR_BAD:
            begin
                // copies still agree, only the address is off
                pick = $urandom_range(FLD_SRC, FLD_TGT);
                for (int c = 0; c < COPIES; c++)
                    pay[FIELDS_PER_COPY * c + pick] = pay[FIELDS_PER_COPY * c + pick] ^ flip;
            end
            default: ;
        endcase
        n = (kind == FR_CUT) ? $urandom_range(0, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
        send_byte(SYNC_HI);
        send_byte(SYNC_LO);
        for (int i = 0; i < n; i++)
            send_byte(pay[i]);
        if (kind != FR_CUT)
        begin
            send_byte(END_HI);
            send_byte(END_LO);
        end
    endtask

    task automatic run_mix(input int budget);
        int start;
        int roll;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            roll = $urandom_range(0, 9);
            if (roll <= 5)
            begin
                roll = $urandom_range(0, 9);
                if (roll <= 4)
                    send_frame(FR_GOOD);
                else if (roll <= 6)
                    send_frame(FR_COPY_BAD);
                else if (roll <= 8)
                    send_frame(FR_ADDR_BAD);
                else
                    send_frame(FR_CUT);
            end
            else if (roll <= 7)
                send_ticks($urandom_range(1, 8));
            else
                send_noise($urandom_range(1, 5));
        end
    endtask

    // drop valid, wait for every expected word, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SECOND_LIMIT:  regs_now.second_limit  = val;
            REG_OFFLINE_LIMIT: regs_now.offline_limit = val;
            REG_IDLE_LIMIT:    regs_now.idle_limit    = val;
            REG_SOURCE:        regs_now.source        = val;
            REG_TARGET:        regs_now.target        = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] sec_lim, input logic [7:0] off_lim,
                                  input logic [7:0] idle_lim, input logic [7:0] src,
                                  input logic [7:0] tgt);
        write_reg(REG_SECOND_LIMIT, sec_lim);
        write_reg(REG_OFFLINE_LIMIT, off_lim);
        write_reg(REG_IDLE_LIMIT, idle_lim);
        write_reg(REG_SOURCE, src);
        write_reg(REG_TARGET, tgt);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_BYTE;
        m_tready    = 1'b0;
        stall_phase = '0;

        regs_now.second_limit  = SECOND_LIMIT_RST;
        regs_now.offline_limit = OFFLINE_LIMIT_RST;
        regs_now.idle_limit    = IDLE_LIMIT_RST;
        regs_now.source        = SOURCE_RST;
        regs_now.target        = TARGET_RST;
        foreach (ring[i])
            ring[i] = 8'h00;
        ring_ptr    = '0;
        pay_start   = '0;
        in_frame    = 1'b0;
        last_rx     = 8'h00;
        idle_ticks  = 8'h00;
        sec_ticks   = 8'h00;
        online_secs = 8'h00;
        online      = 1'b0;
        pump_cmd    = 8'h00;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset register values
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                      directed_rows[i].pump_on, directed_rows[i].link_online);
        run_mix(20);
        settle();

        // fastest seconds and drop-out; idle counter runs into saturation
        apply_settings(8'd1, 8'd1, 8'd255, 8'($urandom), 8'($urandom));
        run_mix(35);
        send_ticks(260);
        run_mix(10);
        settle();

        // slowest limits: seconds never elapse, second counter wraps,
        // every tick clears the pointer
        apply_settings(8'd255, 8'd255, 8'd1, 8'h00, 8'hFF);
        run_mix(35);
        send_ticks(260);
        run_mix(10);
        settle();

        apply_settings(8'd3, 8'd2, 8'd5, 8'hFF, 8'h00);
        run_mix(40);
        settle();

        // online-seconds counter wraps while it never reaches its offline limit
        apply_settings(8'd1, 8'd255, 8'($urandom_range(1, 255)), 8'($urandom),
                       8'($urandom));
        run_mix(20);
        send_ticks(520);
        run_mix(10);
        settle();

        apply_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                       8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom));
        run_mix(40);
        settle();

        if (mismatches == 0)
            $display("redundant_frame_link_supervisor_tb: clean");
        else
            $display("redundant_frame_link_supervisor_tb: errors");
        $finish;
    end

endmodule
